/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define RFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("rfd check failed");
// checked at every edge, reset included
`define RFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("rfd check failed");
`else
`define RFD_ASSERT(lbl, clk, rstn, prop)
`define RFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/rfd_pkg.sv */
// widths, types and constants of the refraction pipeline
// no dependencies
`default_nettype none
package rfd_pkg;
    localparam int COMP_W    = 16;
    localparam int FRAC_W    = COMP_W - 2;
    localparam int ETA_W     = 16;
    localparam int ETA_FRAC  = 13;
    localparam int ETA2_FRAC = 2 * ETA_FRAC;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CI_W      = SUM_W - FRAC_W;
    localparam int EC_W      = ETA_W + 1 + CI_W;
    localparam int ETA2_W    = 2 * ETA_W;
    localparam int S2I_W     = FRAC_W + 1;
    localparam int S2P_W     = ETA2_W + S2I_W;
    localparam int S2T_W     = S2P_W - ETA2_FRAC;
    localparam int SQ_W      = 2 * FRAC_W + 2;
    localparam int SQ_STEPS  = FRAC_W + 1;
    localparam int CT_W      = FRAC_W + 1;
    localparam int SC_W      = EC_W - ETA_FRAC + 1;
    localparam int NP_W      = ETA_W + 1 + COMP_W + 1;
    localparam int T1_W      = NP_W - ETA_FRAC;
    localparam int T2P_W     = SC_W + COMP_W;
    localparam int T2_W      = T2P_W - FRAC_W;
    localparam int DS_W      = T2_W + 1;

    localparam logic [FRAC_W:0] FIX_ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef t_comp [2:0] t_vec;

    typedef struct packed {
        t_comp             out_x;
        t_comp             out_y;
        t_comp             out_z;
        t_comp             normal_x;
        t_comp             normal_y;
        t_comp             normal_z;
        logic [ETA_W-1:0]  index_ratio;
    } t_in;

    typedef struct packed {
        t_comp dir_x;
        t_comp dir_y;
        t_comp dir_z;
        logic  transmitted;
    } t_out;

    typedef struct packed {
        t_vec             wo;
        t_vec             nv;
        logic [ETA_W-1:0] eta;
    } t_carry;

    typedef struct packed {
        t_carry                  c;
        logic signed [EC_W-1:0]  ec;
        logic                    tir;
        logic [SQ_W-1:0]         rad;
    } t_mid;

    typedef struct packed {
        t_carry                  c;
        logic signed [EC_W-1:0]  ec;
        logic                    tir;
        logic [CT_W-1:0]         cos_t;
    } t_root;
endpackage
`default_nettype wire

/* hw/rtl/rfd_if.sv */
// request and result channels of the refraction block
// depends on rfd_pkg
`default_nettype none
interface rfd_in_if;
    import rfd_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rfd_out_if;
    import rfd_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rfd_front.sv */
// front stages: dot product, sin squared, eta squared scaling, radicand
// depends on rfd_pkg
`default_nettype none
module rfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rfd_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rfd_pkg::t_mid  o_data
);
    import rfd_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0] r_v;
    logic [NST:0]   en;

    always_comb begin
        en[NST] = i_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage a: component products and eta squared
    t_carry                     cin;
    t_carry                     r_a_c;
    logic signed [PROD_W-1:0]   r_a_p [3];
    logic [ETA2_W-1:0]          r_a_eta2;

    always_comb begin
        cin.wo[0] = i_data.out_x;
        cin.wo[1] = i_data.out_y;
        cin.wo[2] = i_data.out_z;
        cin.nv[0] = i_data.normal_x;
        cin.nv[1] = i_data.normal_y;
        cin.nv[2] = i_data.normal_z;
        cin.eta   = i_data.index_ratio;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_c    <= cin;
            for (int k = 0; k < 3; k++) begin
                r_a_p[k] <= $signed(cin.wo[k]) * $signed(cin.nv[k]);
            end
            r_a_eta2 <= cin.eta * cin.eta;
        end
    end

    // stage b: exact sum, floored to cos_i
    logic signed [SUM_W-1:0]  dsum;
    t_carry                   r_b_c;
    logic [ETA2_W-1:0]        r_b_eta2;
    logic signed [CI_W-1:0]   r_b_ci;

    assign dsum = SUM_W'(r_a_p[0]) + SUM_W'(r_a_p[1]) + SUM_W'(r_a_p[2]);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_c    <= r_a_c;
            r_b_eta2 <= r_a_eta2;
            r_b_ci   <= dsum[SUM_W-1:FRAC_W];
        end
    end

    // stage c: cos_i squared and eta * cos_i
    logic [CI_W-1:0]          a_abs;
    logic [2*FRAC_W-1:0]      a_sq;
    t_carry                   r_c_c;
    logic [ETA2_W-1:0]        r_c_eta2;
    logic                     r_c_big;
    logic [FRAC_W-1:0]        r_c_sqh;
    logic signed [EC_W-1:0]   r_c_ec;

    assign a_abs = r_b_ci[CI_W-1] ? CI_W'(-r_b_ci) : CI_W'(r_b_ci);
    assign a_sq  = a_abs[FRAC_W-1:0] * a_abs[FRAC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_c    <= r_b_c;
            r_c_eta2 <= r_b_eta2;
            r_c_big  <= |a_abs[CI_W-1:FRAC_W];
            r_c_sqh  <= a_sq[2*FRAC_W-1:FRAC_W];
            r_c_ec   <= $signed({1'b0, r_b_c.eta}) * r_b_ci;
        end
    end

    // stage d: sin2_i times eta squared
    logic [S2I_W-1:0]         sin2_i;
    t_carry                   r_d_c;
    logic signed [EC_W-1:0]   r_d_ec;
    logic [S2P_W-1:0]         r_d_prod;

    assign sin2_i = r_c_big ? '0 : FIX_ONE - {1'b0, r_c_sqh};

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_c    <= r_c_c;
            r_d_ec   <= r_c_ec;
            r_d_prod <= r_c_eta2 * sin2_i;
        end
    end

    // stage e: reflection test and radicand of the root
    logic [S2T_W-1:0]  sin2_t;
    logic [FRAC_W:0]   diff;
    t_mid              r_e;

    assign sin2_t = r_d_prod[S2P_W-1:ETA2_FRAC];
    assign diff   = FIX_ONE - sin2_t[FRAC_W:0];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_e.c   <= r_d_c;
            r_e.ec  <= r_d_ec;
            r_e.tir <= sin2_t >= S2T_W'(FIX_ONE);
            r_e.rad <= {1'b0, diff, {FRAC_W{1'b0}}};
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_data  = r_e;
endmodule
`default_nettype wire

/* hw/rtl/rfd_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on rfd_pkg
`default_nettype none
module rfd_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rfd_pkg::t_mid   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rfd_pkg::t_root  o_data
);
    import rfd_pkg::*;

    typedef struct packed {
        t_carry                  c;
        logic signed [EC_W-1:0]  ec;
        logic                    tir;
        logic [SQ_W-1:0]         rem;
        logic [SQ_W-1:0]         res;
    } t_sqs;

    logic [SQ_STEPS-1:0] r_v;
    logic [SQ_STEPS:0]   en;
    t_sqs                w_src [SQ_STEPS];
    t_sqs                n_st  [SQ_STEPS];
    t_sqs                r_st  [SQ_STEPS];

    always_comb begin
        en[SQ_STEPS] = i_ready;
        for (int s = SQ_STEPS - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < SQ_STEPS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_comb begin
        w_src[0].c   = i_data.c;
        w_src[0].ec  = i_data.ec;
        w_src[0].tir = i_data.tir;
        w_src[0].rem = i_data.rad;
        w_src[0].res = '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (FRAC_W - k));
        logic [SQ_W-1:0] trial;

        if (k > 0) begin : g_link
            assign w_src[k] = r_st[k-1];
        end

        assign trial = w_src[k].res + BIT;

        always_comb begin
            n_st[k] = w_src[k];
            if (w_src[k].rem >= trial) begin
                n_st[k].rem = w_src[k].rem - trial;
                n_st[k].res = (w_src[k].res >> 1) + BIT;
            end else begin
                n_st[k].res = w_src[k].res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready      = en[0];
    assign o_valid      = r_v[SQ_STEPS-1];
    assign o_data.c     = r_st[SQ_STEPS-1].c;
    assign o_data.ec    = r_st[SQ_STEPS-1].ec;
    assign o_data.tir   = r_st[SQ_STEPS-1].tir;
    assign o_data.cos_t = r_st[SQ_STEPS-1].res[CT_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/rfd_back.sv */
// back stages: normal scale, both terms per axis, sum, saturation
// depends on rfd_pkg
`default_nettype none
module rfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rfd_pkg::t_root  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rfd_pkg::t_out   o_data
);
    import rfd_pkg::*;

    localparam int NST = 3;
    localparam logic signed [DS_W-1:0] SAT_HI =
        {{(DS_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [DS_W-1:0] SAT_LO =
        {{(DS_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    logic [NST-1:0] r_v;
    logic [NST:0]   en;

    always_comb begin
        en[NST] = i_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 1: scale = floor(eta * cos_i) - cos_t, and -eta * wo terms
    logic signed [SC_W-1:0]  scale;
    logic signed [NP_W-1:0]  np [3];
    logic signed [SC_W-1:0]  r_p1_scale;
    logic signed [T1_W-1:0]  r_p1_t1 [3];
    t_vec                    r_p1_nv;
    logic                    r_p1_tir;

    assign scale = SC_W'($signed(i_data.ec[EC_W-1:ETA_FRAC]))
                 - $signed({{(SC_W-CT_W){1'b0}}, i_data.cos_t});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            np[k] = -(NP_W'($signed({1'b0, i_data.c.eta}) * $signed(i_data.c.wo[k])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p1_scale <= scale;
            for (int k = 0; k < 3; k++) begin
                r_p1_t1[k] <= np[k][NP_W-1:ETA_FRAC];
            end
            r_p1_nv  <= i_data.c.nv;
            r_p1_tir <= i_data.tir;
        end
    end

    // stage 2: floor(scale * n) per axis
    logic signed [T2P_W-1:0] t2p [3];
    logic signed [T1_W-1:0]  r_p2_t1 [3];
    logic signed [T2_W-1:0]  r_p2_t2 [3];
    logic                    r_p2_tir;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t2p[k] = r_p1_scale * $signed(r_p1_nv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_p2_t1[k] <= r_p1_t1[k];
                r_p2_t2[k] <= t2p[k][T2P_W-1:FRAC_W];
            end
            r_p2_tir <= r_p1_tir;
        end
    end

    // stage 3: add, saturate, zero on reflection
    logic signed [DS_W-1:0] dsum [3];
    t_comp                  dsat [3];
    t_out                   r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dsum[k] = DS_W'(r_p2_t1[k]) + DS_W'(r_p2_t2[k]);
            if (r_p2_tir) begin
                dsat[k] = '0;
            end else if (dsum[k] > SAT_HI) begin
                dsat[k] = SAT_HI[COMP_W-1:0];
            end else if (dsum[k] < SAT_LO) begin
                dsat[k] = SAT_LO[COMP_W-1:0];
            end else begin
                dsat[k] = dsum[k][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_out.dir_x       <= dsat[0];
            r_out.dir_y       <= dsat[1];
            r_out.dir_z       <= dsat[2];
            r_out.transmitted <= !r_p2_tir;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_data  = r_out;
endmodule
`default_nettype wire

/* hw/rtl/refraction_direction.sv */
// Snell refraction of one direction per request, top level of the pipeline.
// A request can enter every cycle unless every stage is full and the result is
// stalled; it passes five front stages (dot product, sin squared, eta squared
// scaling, radicand), one stage per bit of the 15-bit square root, and three
// back stages (normal scale, per-axis terms, sum and saturation). The square
// root chain holds most stages, one restoring step per stage. Each stage holds
// its data when the stage after it is full and stalled, so bubbles close up and
// no request is lost or repeated; the result register keeps a finished result
// while new requests still enter. Vectors are signed Q2.14, eta unsigned Q3.13;
// a total internal reflection gives a zero direction with transmitted low.
// depends on rfd_pkg, rfd_if, rfd_front, rfd_sqrt, rfd_back, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module refraction_direction (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfd_in_if.sink    i_req,
    rfd_out_if.source o_rsp
);
    import rfd_pkg::*;

    // front to root
    logic  fr_valid;
    logic  fr_ready;
    t_mid  fr_data;

    // root to back
    logic  sq_valid;
    logic  sq_ready;
    t_root sq_data;

    // dot product through radicand
    rfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (i_req.data),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_data  (fr_data)
    );

    // cos_t = floor(sqrt(radicand))
    rfd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  (fr_data),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_data  (sq_data)
    );

    // refracted direction, ends in the result register
    rfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_data  (sq_data),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (o_rsp.data)
    );

    // a reflected result always carries a zero direction
    `RFD_ASSERT(a_tir_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.data.transmitted |-> o_rsp.data.dir_x == '0 && o_rsp.data.dir_y == '0 && o_rsp.data.dir_z == '0)
    // with the result register empty, no stage can be holding back the input
    `RFD_ASSERT(a_empty_ready, i_clk, i_rst_n, !o_rsp.valid |-> i_req.ready)
    // reset empties the pipeline
    `RFD_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_rsp.valid)
endmodule
`default_nettype wire

/* verif/refraction_direction_tb.sv */
// testbench for refraction_direction: random and directed refraction requests
// predicts each result with a local fixed-point model; depends on rfd_pkg, rfd_if
`timescale 1ns / 100ps
`default_nettype none

class refraction_scoreboard;
    rfd_pkg::t_out pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // floor shift of a signed value
    static function longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    static function longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 40;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function rfd_pkg::t_comp clamp_comp(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return rfd_pkg::t_comp'(v);
    endfunction

    // work out the refracted direction of one request
    function void note_request(rfd_pkg::t_in r);
        longint wo[3];
        longint nv[3];
        longint eta, cos_i, mag, sin2_i, sin2_t, cos_t, scale;
        longint d[3];
        rfd_pkg::t_out e;
        wo[0] = r.out_x;    wo[1] = r.out_y;    wo[2] = r.out_z;
        nv[0] = r.normal_x; nv[1] = r.normal_y; nv[2] = r.normal_z;
        eta = longint'(r.index_ratio);
        // exact dot product then one floor of the sum, as the front stage does
        cos_i = floor_sh(nv[0] * wo[0] + nv[1] * wo[1] + nv[2] * wo[2], 14);
        mag = cos_i < 0 ? -cos_i : cos_i;
        sin2_i = (mag < 16384) ? 16384 - ((mag * mag) >> 14) : 0;
        sin2_t = (eta * eta * sin2_i) >> 26;
        e = '0;
        if (sin2_t < 16384) begin
            cos_t = int_sqrt((16384 - sin2_t) << 14);
            scale = floor_sh(eta * cos_i, 13) - cos_t;
            for (int k = 0; k < 3; k++)
                d[k] = floor_sh(-(eta * wo[k]), 13) + floor_sh(scale * nv[k], 14);
            e.dir_x = clamp_comp(d[0]);
            e.dir_y = clamp_comp(d[1]);
            e.dir_z = clamp_comp(d[2]);
            e.transmitted = 1'b1;
        end
        pending.push_back(e);
    endfunction

    function void check_result(rfd_pkg::t_out got);
        rfd_pkg::t_out e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.dir_x !== e.dir_x)
            $display("%0t: dir_x expected %0d actual %0d", $time, e.dir_x, got.dir_x);
        if (got.dir_y !== e.dir_y)
            $display("%0t: dir_y expected %0d actual %0d", $time, e.dir_y, got.dir_y);
        if (got.dir_z !== e.dir_z)
            $display("%0t: dir_z expected %0d actual %0d", $time, e.dir_z, got.dir_z);
        if (got.transmitted !== e.transmitted)
            $display("%0t: transmitted expected %0b actual %0b", $time,
                     e.transmitted, got.transmitted);
        if (got !== e) errors++;
    endfunction
endclass

module refraction_direction_tb;
    import rfd_pkg::*;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 60;

    logic i_clk;
    logic i_rst_n;
    rfd_in_if  req_ch();
    rfd_out_if rsp_ch();

    refraction_direction i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    refraction_scoreboard board = new();
    int  cycles = 0;
    bit  calm = 0;       // no idling on either side while set

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.data);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side stalls at random, except in the calm stretch
    always @(negedge i_clk) begin
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // send one request; holds valid until accepted, may idle first
    task automatic send_request(t_in r);
        if (!calm) begin
            while ($urandom_range(99) < 33) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_comp rand_comp();
        case ($urandom_range(5))
            0: return t_comp'($urandom);
            1: return t_comp'(16'sh8000);
            2: return t_comp'(16'sh7fff);
            default: return t_comp'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // mostly near-unit vectors, some raw patterns
    function automatic t_in rand_request();
        t_in r;
        real th, ph;
        r.out_x = rand_comp(); r.out_y = rand_comp(); r.out_z = rand_comp();
        r.normal_x = rand_comp(); r.normal_y = rand_comp(); r.normal_z = rand_comp();
        if ($urandom_range(99) < 70) begin
            th = $urandom_range(6283) / 1000.0;
            ph = $urandom_range(3141) / 1000.0;
            r.out_x = t_comp'($rtoi(16384.0 * $sin(ph) * $cos(th)));
            r.out_y = t_comp'($rtoi(16384.0 * $sin(ph) * $sin(th)));
            r.out_z = t_comp'($rtoi(16384.0 * $cos(ph)));
            r.normal_x = '0; r.normal_y = '0;
            r.normal_z = $urandom_range(1) ? t_comp'(16384) : t_comp'(-16384);
        end
        case ($urandom_range(4))
            0: r.index_ratio = 16'($urandom);
            1: r.index_ratio = 16'($urandom_range(16384, 4096));
            default: r.index_ratio = 16'($urandom_range(12288, 5461));
        endcase
        return r;
    endfunction

    function automatic t_in make_request(int ox, int oy, int oz, int nx, int ny, int nz,
                                         int eta);
        t_in r;
        r.out_x = t_comp'(ox); r.out_y = t_comp'(oy); r.out_z = t_comp'(oz);
        r.normal_x = t_comp'(nx); r.normal_y = t_comp'(ny); r.normal_z = t_comp'(nz);
        r.index_ratio = 16'(eta);
        return r;
    endfunction

    initial begin
        int  wait_cycles;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: normal incidence, grazing, zero eta, total reflection,
        // extreme patterns and saturation
        send_request(make_request(0, 0, 16384, 0, 0, 16384, 8192));
        send_request(make_request(0, 0, 16384, 0, 0, -16384, 12288));
        send_request(make_request(16384, 0, 0, 0, 0, 16384, 8192));
        send_request(make_request(11585, 0, 11585, 0, 0, 16384, 0));
        send_request(make_request(11585, 0, 11585, 0, 0, 16384, 16384));
        send_request(make_request(15000, 0, 6000, 0, 0, 16384, 12000));
        send_request(make_request(11585, 0, 11585, 0, 0, 16384, 65535));
        send_request(make_request(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        send_request(make_request(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_request(make_request(32767, -32768, 32767, -32768, 32767, -32768, 1));
        send_request(make_request(32767, 0, 0, -32768, 0, 0, 65535));
        send_request(make_request(0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(0, 0, 0, 32767, -32768, 32767, 8192));
        send_request(make_request(-32768, 32767, 0, 0, 0, 0, 65535));
        send_request(make_request(5000, -3000, 15000, 300, -200, 16380, 6000));
        send_request(make_request(-1, -1, -1, -1, -1, -1, 65535));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm = (n >= 600 && n < 800);
            send_request(rand_request());
        end
        calm = 0;
        req_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
